>>> sv/wrft_pkg.sv
`timescale 1ns / 1ps
package wrft_pkg;

  // One pose update: a 3x4 affine transform, signed fixed point.
  typedef struct packed {
    logic signed [31:0] t00;
    logic signed [31:0] t01;
    logic signed [31:0] t02;
    logic signed [31:0] t03;
    logic signed [31:0] t10;
    logic signed [31:0] t11;
    logic signed [31:0] t12;
    logic signed [31:0] t13;
    logic signed [31:0] t20;
    logic signed [31:0] t21;
    logic signed [31:0] t22;
    logic signed [31:0] t23;
  } in_t;

  // One result: the three angles and the distance of this update.
  typedef struct packed {
    logic [24:0] yaw_angle;
    logic [24:0] pitch_angle;
    logic [24:0] roll_angle;
    logic [31:0] distance_moved;
  } out_t;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_AXIS   = 3'd0;
  localparam logic [2:0] REG_RADIUS = 3'd1;
  localparam logic [2:0] REG_REF_X  = 3'd2;
  localparam logic [2:0] REG_REF_Y  = 3'd3;
  localparam logic [2:0] REG_REF_Z  = 3'd4;

  // Axis codes.
  localparam logic [1:0] AXIS_YAW   = 2'd0;
  localparam logic [1:0] AXIS_PITCH = 2'd1;
  localparam logic [1:0] AXIS_ROLL  = 2'd2;

  // Pi as an unsigned fraction with 30 fraction bits.
  localparam logic [31:0] PI_Q30 = 32'd3373259426;

endpackage

>>> sv/wrft_sqrt.sv
`timescale 1ns / 1ps
module wrft_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] val;
  logic [33:0] rem;
  logic [4:0]  cnt;
  logic        busy;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        fits;

  // One result bit per cycle: bring in two radicand bits and try the next root bit.
  assign rem_sh = {rem, val[63:62]};
  assign trial  = {2'b00, root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        val  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        val <= {val[61:0], 2'b00};
        if (fits) begin
          rem  <= 34'(rem_sh - trial);
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= rem_sh[33:0];
          root <= {root[30:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> sv/wrft_div.sv
`timescale 1ns / 1ps
module wrft_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [31:0]           distance,
  input  logic [62:0]           divisor,
  output logic                  done,
  output logic [FRAC_BITS+8:0]  step
);

  localparam int AW = FRAC_BITS + 9;
  localparam int N  = 70 + FRAC_BITS;
  localparam int CW = $clog2(N + 1);
  localparam logic [AW:0] MODULUS = (AW + 1)'(360) << FRAC_BITS;

  logic [39:0]   num;
  logic [63:0]   rem;
  logic [62:0]   dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [39:0]   num_init;
  logic [63:0]   rem_sh;
  logic          qbit;
  logic [AW:0]   qm_sh;

  // Dividend is the distance times 180, made of four shifted copies.
  assign num_init = ({8'b0, distance} << 7) + ({8'b0, distance} << 5)
                  + ({8'b0, distance} << 4) + ({8'b0, distance} << 2);

  // Restoring division, one quotient bit per cycle; zeros follow the dividend bits.
  assign rem_sh = {rem[62:0], num[39]};
  assign qbit   = rem_sh >= {1'b0, dvs};
  // The quotient is reduced modulo a full turn as its bits arrive.
  assign qm_sh  = {step, qbit};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        num  <= num_init;
        rem  <= '0;
        dvs  <= divisor;
        step <= '0;
      end else if (busy) begin
        num <= {num[38:0], 1'b0};
        if (qbit) begin
          rem <= rem_sh - {1'b0, dvs};
        end else begin
          rem <= rem_sh;
        end
        if (qm_sh >= MODULUS) begin
          step <= AW'(qm_sh - MODULUS);
        end else begin
          step <= qm_sh[AW-1:0];
        end
        cnt <= cnt + CW'(1);
        if (cnt == CW'(N - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> sv/wheel_rotation_from_travel.sv
`timescale 1ns / 1ps
// Wheel rotation from travel. Each request carries one pose transform; the block
// maps the configured reference point through it, measures the distance from the
// point of the previous request (the origin after reset), and turns the selected
// angle by distance / (2 * pi * radius) full turns, kept in [0, 360) degrees. One
// result follows each request. An update runs on the shared 33x33 multiplier, then in
// the bit-serial square root, then in the bit-serial divider, which takes longest. A
// zero radius skips the divider and leaves the angles unchanged. One request is worked
// on at a time; a new one is taken while the previous result waits at the output.
module wheel_rotation_from_travel
  import wrft_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = FRAC_BITS + 9;
  localparam logic [AW:0] MODULUS = (AW + 1)'(360) << FRAC_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_ANG  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  state;
  logic [1:0]  axis_select;
  logic [30:0] wheel_radius;
  logic [31:0] ref_pt [3];
  logic [31:0] prev_pt [3];
  logic [31:0] pt [3];
  logic [AW-1:0] angles [3];
  in_t         xf;
  logic [3:0]  k;
  logic [3:0]  pk;
  logic        pv;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [63:0] sqsum;
  logic [62:0] divisor;
  logic [31:0] distance;

  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic signed [65:0] mp;
  logic [1:0]  dsel;
  logic signed [32:0] delta;
  logic [32:0] mag;
  logic [63:0] acc_sum;
  logic [31:0] coord;
  logic [31:0] trans;
  logic [64:0] sq_add;
  logic        cfg_wr;
  logic        sq_start;
  logic        sq_done;
  logic [31:0] sq_root;
  logic        div_start;
  logic        div_done;
  logic [AW-1:0] step;
  logic [1:0]  ax;
  logic [AW:0] ang_sum;
  logic [AW+24:0] pad0;
  logic [AW+24:0] pad1;
  logic [AW+24:0] pad2;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_select  <= AXIS_ROLL;
      wheel_radius <= 31'd14418;
      ref_pt[0]    <= '0;
      ref_pt[1]    <= '0;
      ref_pt[2]    <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_AXIS:   axis_select  <= pwdata[1:0];
        REG_RADIUS: wheel_radius <= pwdata[30:0];
        REG_REF_X:  ref_pt[0]    <= pwdata;
        REG_REF_Y:  ref_pt[1]    <= pwdata;
        REG_REF_Z:  ref_pt[2]    <= pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_AXIS:   prdata = {30'b0, axis_select};
      REG_RADIUS: prdata = {1'b0, wheel_radius};
      REG_REF_X:  prdata = ref_pt[0];
      REG_REF_Y:  prdata = ref_pt[1];
      REG_REF_Z:  prdata = ref_pt[2];
      default:    prdata = '0;
    endcase
  end

  // Delta of one coordinate and its magnitude for the square terms.
  assign dsel  = (k == 4'd9) ? 2'd0 : ((k == 4'd10) ? 2'd1 : 2'd2);
  assign delta = {pt[dsel][31], pt[dsel]} - {prev_pt[dsel][31], prev_pt[dsel]};
  assign mag   = delta[32] ? 33'(-delta) : delta;

  // Operands of the shared multiplier, one term per cycle.
  always_comb begin
    case (k)
      4'd0:    begin ma = 33'(xf.t00); mb = 33'(signed'(ref_pt[0])); end
      4'd1:    begin ma = 33'(xf.t01); mb = 33'(signed'(ref_pt[1])); end
      4'd2:    begin ma = 33'(xf.t02); mb = 33'(signed'(ref_pt[2])); end
      4'd3:    begin ma = 33'(xf.t10); mb = 33'(signed'(ref_pt[0])); end
      4'd4:    begin ma = 33'(xf.t11); mb = 33'(signed'(ref_pt[1])); end
      4'd5:    begin ma = 33'(xf.t12); mb = 33'(signed'(ref_pt[2])); end
      4'd6:    begin ma = 33'(xf.t20); mb = 33'(signed'(ref_pt[0])); end
      4'd7:    begin ma = 33'(xf.t21); mb = 33'(signed'(ref_pt[1])); end
      4'd8:    begin ma = 33'(xf.t22); mb = 33'(signed'(ref_pt[2])); end
      4'd9, 4'd10, 4'd11: begin
        ma = {1'b0, mag[31:0]};
        mb = {1'b0, mag[31:0]};
      end
      4'd12:   begin ma = {1'b0, PI_Q30}; mb = {2'b00, wheel_radius}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end
  assign mp = ma * mb;

  // Accumulate side: finish a row with its translation, or add a saturated square.
  assign acc_sum = acc + prod;
  assign coord   = acc_sum[FRAC_BITS+31:FRAC_BITS];
  assign trans   = (pk == 4'd2) ? xf.t03 : ((pk == 4'd5) ? xf.t13 : xf.t23);
  assign sq_add  = {1'b0, sqsum} + {1'b0, prod};

  assign sq_start  = (state == S_MUL) && pv && (pk == 4'd12);
  assign div_start = (state == S_SQRT) && sq_done && (wheel_radius != '0);

  // Angle update on the selected axis; the unused code turns yaw.
  assign ax      = (axis_select == 2'd3) ? AXIS_YAW : axis_select;
  assign ang_sum = {1'b0, angles[ax]} + {1'b0, step};

  assign pad0 = {25'b0, angles[0]};
  assign pad1 = {25'b0, angles[1]};
  assign pad2 = {25'b0, angles[2]};

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      pv         <= 1'b0;
      k          <= '0;
      pk         <= '0;
      prev_pt[0] <= '0;
      prev_pt[1] <= '0;
      prev_pt[2] <= '0;
      angles[0]  <= '0;
      angles[1]  <= '0;
      angles[2]  <= '0;
    end else begin
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            xf    <= in_data;
            k     <= '0;
            pv    <= 1'b0;
            acc   <= '0;
            sqsum <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // Issue one product per cycle, consume it the next.
          if (k <= 4'd12) begin
            prod <= mp[63:0];
            pk   <= k;
            pv   <= 1'b1;
            k    <= k + 4'd1;
          end else begin
            pv <= 1'b0;
          end
          if (pv) begin
            case (pk)
              4'd2: begin
                pt[0] <= coord + trans;
                acc   <= '0;
              end
              4'd5: begin
                pt[1] <= coord + trans;
                acc   <= '0;
              end
              4'd8: begin
                pt[2] <= coord + trans;
                acc   <= '0;
              end
              4'd9, 4'd10, 4'd11: begin
                sqsum <= sq_add[64] ? '1 : sq_add[63:0];
              end
              4'd12: begin
                divisor <= prod[62:0];
                state   <= S_SQRT;
              end
              default: acc <= acc_sum;
            endcase
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            distance <= sq_root;
            state    <= (wheel_radius != '0) ? S_DIV : S_OUT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_ANG;
          end
        end
        S_ANG: begin
          if (ang_sum >= MODULUS) begin
            angles[ax] <= AW'(ang_sum - MODULUS);
          end else begin
            angles[ax] <= ang_sum[AW-1:0];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          // Hand the result over once the output register is free.
          if (!out_valid || out_ready) begin
            out_valid                <= 1'b1;
            out_data.yaw_angle      <= pad0[24:0];
            out_data.pitch_angle    <= pad1[24:0];
            out_data.roll_angle     <= pad2[24:0];
            out_data.distance_moved <= distance;
            prev_pt[0] <= pt[0];
            prev_pt[1] <= pt[1];
            prev_pt[2] <= pt[2];
            state      <= S_IDLE;
          end else if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  wrft_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sqsum),
    .done     (sq_done),
    .root     (sq_root)
  );

  wrft_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .distance (sq_root),
    .divisor  (divisor),
    .done     (div_done),
    .step     (step)
  );

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_MUL)
    else $error("accepted request did not start the multiplier sequence");

  a_angles_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, angles[0]} < MODULUS) && ({1'b0, angles[1]} < MODULUS)
    && ({1'b0, angles[2]} < MODULUS))
    else $error("stored angle reached a full turn");

  a_sqrt_done: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> state == S_SQRT)
    else $error("square root finished outside its phase");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV) && ({1'b0, step} < MODULUS))
    else $error("divider finished out of phase or with an unreduced step");
`endif

endmodule

>>> verif/wheel_rotation_from_travel_test.sv
`timescale 1ns / 1ps
module wheel_rotation_from_travel_test;
  import wrft_pkg::*;

  localparam int FRAC = 16;
  localparam logic [63:0] TURN = 64'd360 << FRAC;
  localparam int IDLE_LIMIT = 20000;
  localparam int PHASES = 8;
  localparam int PER_PHASE = 235;

  // Wheel predictor and the queue of pending expected results.
  class wheel_scoreboard;
    logic [1:0] axis;
    logic [30:0] radius;
    logic [31:0] ref_pt[3];
    logic [31:0] last_pt[3];
    logic [63:0] angle[3];
    out_t pending[$];
    int errors;

    function new();
      axis = AXIS_ROLL;
      radius = 31'd14418;
      errors = 0;
      for (int i = 0; i < 3; i++) begin
        ref_pt[i] = '0;
        last_pt[i] = '0;
        angle[i] = '0;
      end
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_AXIS: axis = val[1:0];
        REG_RADIUS: radius = val[30:0];
        REG_REF_X: ref_pt[0] = val;
        REG_REF_Y: ref_pt[1] = val;
        REG_REF_Z: ref_pt[2] = val;
        default: ;
      endcase
    endfunction

    // One transformed coordinate: row dot reference point, rescaled, plus translation.
    function logic [31:0] map_coord(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                    logic [31:0] t);
      longint acc;
      logic [63:0] bits;
      acc = longint'(signed'(a)) * longint'(signed'(ref_pt[0]))
          + longint'(signed'(b)) * longint'(signed'(ref_pt[1]))
          + longint'(signed'(c)) * longint'(signed'(ref_pt[2]));
      bits = acc;
      return bits[47:16] + t;
    endfunction

    function logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res = '0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // Long division of distance*180*2^(30+FRAC) by pi*radius, keeping 64 quotient bits.
    function logic [63:0] turn_step(logic [31:0] distance);
      logic [63:0] num, divisor, rem, q;
      num = 64'(distance) * 64'd180;
      divisor = 64'(PI_Q30) * 64'(radius);
      rem = '0;
      q = '0;
      for (int i = 0; i < 40 + 30 + FRAC; i++) begin
        rem = {rem[62:0], (i < 40) ? num[39 - i] : 1'b0};
        q = q << 1;
        if (rem >= divisor) begin
          rem = rem - divisor;
          q[0] = 1'b1;
        end
      end
      return q;
    endfunction

    function void note_request(in_t req);
      logic [31:0] pt[3];
      logic [64:0] total;
      logic [63:0] sum, mag;
      longint d;
      logic [31:0] distance;
      int ax;
      out_t res;
      pt[0] = map_coord(req.t00, req.t01, req.t02, req.t03);
      pt[1] = map_coord(req.t10, req.t11, req.t12, req.t13);
      pt[2] = map_coord(req.t20, req.t21, req.t22, req.t23);
      sum = '0;
      for (int r = 0; r < 3; r++) begin
        d = longint'(signed'(pt[r])) - longint'(signed'(last_pt[r]));
        mag = (d < 0) ? -d : d;
        total = 65'(sum) + 65'(mag * mag);
        sum = total[64] ? '1 : total[63:0];
      end
      distance = 32'(floor_sqrt(sum));
      if (radius != 0) begin
        ax = (axis == AXIS_PITCH) ? 1 : (axis == AXIS_ROLL) ? 2 : 0;
        angle[ax] = (angle[ax] + turn_step(distance) % TURN) % TURN;
      end
      for (int r = 0; r < 3; r++) last_pt[r] = pt[r];
      res.yaw_angle = angle[0][24:0];
      res.pitch_angle = angle[1][24:0];
      res.roll_angle = angle[2][24:0];
      res.distance_moved = distance;
      pending.push_back(res);
    endfunction

    function void check_result(out_t got);
      out_t exp_res;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (got.yaw_angle !== exp_res.yaw_angle) begin
        $display("%0t: yaw expected %h got %h", $time, exp_res.yaw_angle, got.yaw_angle);
        errors++;
      end
      if (got.pitch_angle !== exp_res.pitch_angle) begin
        $display("%0t: pitch expected %h got %h", $time, exp_res.pitch_angle,
                 got.pitch_angle);
        errors++;
      end
      if (got.roll_angle !== exp_res.roll_angle) begin
        $display("%0t: roll expected %h got %h", $time, exp_res.roll_angle, got.roll_angle);
        errors++;
      end
      if (got.distance_moved !== exp_res.distance_moved) begin
        $display("%0t: distance expected %h got %h", $time, exp_res.distance_moved,
                 got.distance_moved);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  wheel_scoreboard wheel_sb = new();
  bit calm = 1'b0;
  int idle_cycles = 0;
  int ready_hold = 0;
  logic [31:0] travel[3];

  wheel_rotation_from_travel dut (.*);

  always #6 clk = ~clk;

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Result side: check accepted results, then pick the next ready level.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) wheel_sb.check_result(out_data);
      if (ready_hold > 0) begin
        ready_hold--;
      end else if (calm || $urandom_range(0, 1)) begin
        out_ready <= 1'b1;
        ready_hold = $urandom_range(1, 30);
      end else begin
        out_ready <= 1'b0;
        ready_hold = pick_gap();
      end
    end
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(in_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    wheel_sb.note_request(req);
  endtask

  task automatic drain();
    @(posedge clk);
    in_valid <= 1'b0;
    while (wheel_sb.pending.size() != 0) @(posedge clk);
  endtask

  // Register write over the APB port; only called while the block is idle.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    wheel_sb.set_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      default: return $urandom();
    endcase
  endfunction

  function automatic in_t pose(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_t p;
    p = '0;
    p.t00 = 32'h0001_0000;
    p.t11 = 32'h0001_0000;
    p.t22 = 32'h0001_0000;
    p.t03 = x;
    p.t13 = y;
    p.t23 = z;
    return p;
  endfunction

  // Plausible motion: near-identity rotation with a small step in position.
  function automatic in_t motion_request();
    in_t p;
    for (int i = 0; i < 3; i++) travel[i] = travel[i] + $urandom_range(0, 8000) - 4000;
    p = pose(travel[0], travel[1], travel[2]);
    p.t00 = 32'h0001_0000 + $urandom_range(0, 4000) - 2000;
    p.t01 = $urandom_range(0, 60000) - 30000;
    p.t02 = $urandom_range(0, 60000) - 30000;
    p.t10 = $urandom_range(0, 60000) - 30000;
    p.t11 = 32'h0001_0000 + $urandom_range(0, 4000) - 2000;
    p.t12 = $urandom_range(0, 60000) - 30000;
    p.t20 = $urandom_range(0, 60000) - 30000;
    p.t21 = $urandom_range(0, 60000) - 30000;
    p.t22 = 32'h0001_0000 + $urandom_range(0, 4000) - 2000;
    return p;
  endfunction

  function automatic in_t random_request();
    logic [11:0][31:0] w;
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return motion_request();
    for (int i = 0; i < 12; i++) w[i] = (r < 85) ? $urandom() : pick_coord();
    return in_t'(w);
  endfunction

  task automatic random_config();
    logic [31:0] rad;
    case ($urandom_range(0, 5))
      0: rad = 32'd1;
      1: rad = 32'h7fff_ffff;
      2: rad = 32'd0;
      3: rad = 32'd14418;
      default: rad = $urandom_range(1000, 2000000);
    endcase
    write_reg(REG_AXIS, $urandom_range(0, 3));
    write_reg(REG_RADIUS, rad);
    write_reg(REG_REF_X, ($urandom_range(0, 2) == 0) ? pick_coord() :
              32'($urandom_range(0, 200000)) - 100000);
    write_reg(REG_REF_Y, ($urandom_range(0, 2) == 0) ? pick_coord() :
              32'($urandom_range(0, 200000)) - 100000);
    write_reg(REG_REF_Z, ($urandom_range(0, 2) == 0) ? pick_coord() :
              32'($urandom_range(0, 200000)) - 100000);
  endtask

  initial begin
    in_t req;
    for (int i = 0; i < 3; i++) travel[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: first move measured from the origin, under reset settings.
    calm = 1'b1;
    send_request(pose(32'h0003_0000, 32'h0004_0000, 32'h0));
    send_request(pose(32'h0003_0000, 32'h0004_0000, 32'h0));
    send_request(pose(32'h0, 32'h0, 32'h0001_0000));
    calm = 1'b0;
    // Coordinates at the extremes: wrapped points and a saturated distance.
    send_request(pose(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_request(pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_request(pose(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    req = '1;
    send_request(req);
    req = '0;
    send_request(req);
    drain();

    // Unused axis code turns yaw; a reference point off the origin.
    write_reg(REG_AXIS, 32'd3);
    write_reg(REG_REF_X, 32'h0001_0000);
    write_reg(REG_REF_Y, 32'h8000_0000);
    write_reg(REG_REF_Z, 32'h7fff_ffff);
    send_request(pose(32'h0010_0000, 32'h0, 32'h0));
    req = {12{32'h8000_0000}};
    send_request(req);
    req = {12{32'h7fff_ffff}};
    send_request(req);
    drain();

    // Zero radius holds the angles; smallest and largest radius; pitch axis.
    write_reg(REG_RADIUS, 32'd0);
    send_request(pose(32'h0100_0000, 32'h0, 32'h0));
    send_request(pose(32'h0, 32'h0, 32'h0));
    drain();
    write_reg(REG_AXIS, 32'(AXIS_PITCH));
    write_reg(REG_RADIUS, 32'd1);
    send_request(pose(32'h0100_0000, 32'h7fff_ffff, 32'h0));
    send_request(pose(32'h0, 32'h0, 32'h0000_0001));
    drain();
    write_reg(REG_AXIS, 32'(AXIS_YAW));
    write_reg(REG_RADIUS, 32'h7fff_ffff);
    send_request(pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_request(pose(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    drain();

    // Random phases, each under a fresh setting.
    for (int ph = 0; ph < PHASES; ph++) begin
      random_config();
      calm = (ph == 2);
      for (int n = 0; n < PER_PHASE; n++) begin
        send_request(random_request());
        // Hold off the sender once until every result is back.
        if (ph == 4 && n == PER_PHASE / 2) drain();
      end
      calm = 1'b0;
      drain();
    end

    repeat (300) @(posedge clk);
    if (wheel_sb.errors == 0 && wheel_sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
